/* sv/hsv_pkg.sv */
package hsv_pkg;

    // field widths
    localparam int unsigned HueW  = 15;
    localparam int unsigned ChanW = 8;
    localparam int unsigned DistW = 12;

    // hue geometry in 1/64 degree units
    localparam logic [HueW-1:0] SectorUnits = 15'd3840;
    localparam logic [HueW-1:0] Hue120      = 15'd7680;
    localparam logic [HueW-1:0] Hue180      = 15'd11520;
    localparam logic [HueW-1:0] Hue240      = 15'd15360;
    localparam logic [HueW-1:0] Hue300      = 15'd19200;
    localparam logic [HueW-1:0] Hue360      = 15'd23040;
    localparam logic [HueW-1:0] Hue480      = 15'd30720;

    // full scale of a channel
    localparam logic [ChanW-1:0] FullScale = 8'd255;

    // 255 * 3840, the denominator of the secondary channel
    localparam logic [19:0] SecDenom = 20'd979200;

    // divide by 255 for 16 bit values: (p * 0x8081) >> 23
    localparam logic [31:0] Recip255 = 32'd32897;
    localparam int unsigned Recip255Sh = 23;

    // divide by 3825: floor(2^28 / 3825), estimate is low by at most one
    localparam logic [36:0] Recip3825 = 37'd70179;
    localparam int unsigned Recip3825Sh = 28;
    localparam logic [19:0] Div3825 = 20'd3825;

    // sector codes
    typedef logic [2:0] t_sector;
    localparam t_sector SecRed     = 3'd0;
    localparam t_sector SecYellow  = 3'd1;
    localparam t_sector SecGreen   = 3'd2;
    localparam t_sector SecCyan    = 3'd3;
    localparam t_sector SecBlue    = 3'd4;
    localparam t_sector SecMagenta = 3'd5;

endpackage

/* sv/hsv_pix_if.sv */
interface hsv_pix_if import hsv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

/* sv/hsv_rgb_if.sv */
interface hsv_rgb_if import hsv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

/* sv/hsv_to_rgb_converter.sv */
// hsv to rgb pixel converter, five register stages
// throughput: one pixel per cycle; the pipeline advances as a whole and
// holds while the output request waits
// reset (synchronous, active low) clears the stage valid bits only
module hsv_to_rgb_converter import hsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsv_pix_if.sink     i_pix,
    hsv_rgb_if.source   o_pix
);

    localparam int unsigned NStage = 5;

    logic [NStage:1] r_vld;
    logic            w_en;

    // stage 1 payload
    logic [ChanW-1:0] r_s1, r_v1;
    t_sector          r_sec1;
    logic [DistW-1:0] r_dist1;
    logic [15:0]      r_pz1;
    // stage 2 payload
    logic [ChanW-1:0] r_v2, r_zc2;
    t_sector          r_sec2;
    logic [19:0]      r_sd2;
    // stage 3 payload
    logic [ChanW-1:0] r_v3, r_zc3;
    t_sector          r_sec3;
    logic [19:0]      r_n3;
    // stage 4 payload
    logic [ChanW-1:0] r_v4, r_zc4, r_qe4;
    t_sector          r_sec4;
    logic [19:0]      r_n4;
    // stage 5 payload
    logic [ChanW-1:0] r_v5, r_red5, r_green5, r_blue5;

    // whole pipeline moves unless the output request is stalled
    assign w_en        = !r_vld[NStage] || o_pix.ready;
    assign i_pix.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NStage-1:1], i_pix.valid};
        end
    end

    // stage 1: sector, fold distance, zero channel numerator
    t_sector          n_sec1;
    logic [HueW-1:0]  w_hm;
    logic [DistW-1:0] n_dist1;
    logic [15:0]      n_pz1;

    always_comb begin
        if (i_pix.hue >= Hue300)      n_sec1 = SecMagenta;
        else if (i_pix.hue >= Hue240) n_sec1 = SecBlue;
        else if (i_pix.hue >= Hue180) n_sec1 = SecCyan;
        else if (i_pix.hue >= Hue120) n_sec1 = SecGreen;
        else if (i_pix.hue >= SectorUnits) n_sec1 = SecYellow;
        else                          n_sec1 = SecRed;

        // position within a 120 degree fold
        if (i_pix.hue >= Hue480)      w_hm = i_pix.hue - Hue480;
        else if (i_pix.hue >= Hue360) w_hm = i_pix.hue - Hue360;
        else if (i_pix.hue >= Hue240) w_hm = i_pix.hue - Hue240;
        else if (i_pix.hue >= Hue120) w_hm = i_pix.hue - Hue120;
        else                          w_hm = i_pix.hue;

        if (w_hm >= SectorUnits) n_dist1 = DistW'(w_hm - SectorUnits);
        else                     n_dist1 = DistW'(SectorUnits - w_hm);

        n_pz1 = {8'd0, i_pix.brightness} * {8'd0, FullScale - i_pix.saturation};
    end

    // stage 2: saturation times distance, zero channel divide by 255
    logic [19:0]      n_sd2;
    logic [31:0]      w_zprod;
    logic [ChanW-1:0] n_zc2;

    always_comb begin
        n_sd2   = 20'(r_s1) * 20'(r_dist1);
        w_zprod = 32'(r_pz1) * Recip255;
        n_zc2   = w_zprod[Recip255Sh +: ChanW];
    end

    // stage 3: secondary numerator, pre-shifted by 256
    logic [27:0] w_num;
    always_comb begin
        w_num = 28'(r_v2) * 28'(SecDenom - r_sd2);
    end

    // stage 4: quotient estimate by 3825
    logic [36:0] w_qprod;
    always_comb begin
        w_qprod = 37'(r_n3) * Recip3825;
    end

    // stage 5: quotient correction and channel routing
    logic [19:0]      w_qmul, w_rem;
    logic [ChanW-1:0] w_xc;
    logic [ChanW-1:0] n_red5, n_green5, n_blue5;

    always_comb begin
        w_qmul = 20'(r_qe4) * Div3825;
        w_rem  = r_n4 - w_qmul;
        w_xc   = r_qe4 + ChanW'(w_rem >= Div3825);

        unique case (r_sec4)
            SecRed:    begin n_red5 = r_v4;  n_green5 = w_xc;  n_blue5 = r_zc4; end
            SecYellow: begin n_red5 = w_xc;  n_green5 = r_v4;  n_blue5 = r_zc4; end
            SecGreen:  begin n_red5 = r_zc4; n_green5 = r_v4;  n_blue5 = w_xc;  end
            SecCyan:   begin n_red5 = r_zc4; n_green5 = w_xc;  n_blue5 = r_v4;  end
            SecBlue:   begin n_red5 = w_xc;  n_green5 = r_zc4; n_blue5 = r_v4;  end
            default:   begin n_red5 = r_v4;  n_green5 = r_zc4; n_blue5 = w_xc;  end
        endcase
    end

    // stage payload registers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1     <= i_pix.saturation;
            r_v1     <= i_pix.brightness;
            r_sec1   <= n_sec1;
            r_dist1  <= n_dist1;
            r_pz1    <= n_pz1;

            r_v2     <= r_v1;
            r_sec2   <= r_sec1;
            r_sd2    <= n_sd2;
            r_zc2    <= n_zc2;

            r_v3     <= r_v2;
            r_sec3   <= r_sec2;
            r_zc3    <= r_zc2;
            r_n3     <= w_num[27:8];

            r_v4     <= r_v3;
            r_sec4   <= r_sec3;
            r_zc4    <= r_zc3;
            r_n4     <= r_n3;
            r_qe4    <= w_qprod[Recip3825Sh +: ChanW];

            r_v5     <= r_v4;
            r_red5   <= n_red5;
            r_green5 <= n_green5;
            r_blue5  <= n_blue5;
        end
    end

    assign o_pix.valid = r_vld[NStage];
    assign o_pix.red   = r_red5;
    assign o_pix.green = r_green5;
    assign o_pix.blue  = r_blue5;

    // accepted request enters stage 1
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_vld[1])
        else $error("accepted pixel did not enter stage 1");

    // stalled pipeline keeps its occupancy
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline occupancy changed during stall");

    // one channel always carries the brightness
    a_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (o_pix.red == r_v5 || o_pix.green == r_v5 || o_pix.blue == r_v5))
        else $error("no channel equals brightness");

    // no channel exceeds the brightness
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (o_pix.red <= r_v5 && o_pix.green <= r_v5 && o_pix.blue <= r_v5))
        else $error("channel above brightness");

endmodule
